// ===== rtl/core/led_pattern_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// led_pattern_sequencer_defines.svh - assertion macros
// Clocked, reset-gated property shorthands for the sequencer's checker.
// ----------------------------------------------------------------------------
`ifndef LED_PATTERN_SEQUENCER_DEFINES_SVH
`define LED_PATTERN_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lps check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lps check failed");

`endif

// ===== rtl/core/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg - shared types and constants of the LED pattern sequencer
// Command codes, field widths and the constant pattern table.
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

    localparam int OP_W         = 2;
    localparam int PAT_W        = 3;
    localparam int STEP_W       = 3;
    localparam int LED_W        = 3;
    localparam int MS_W         = 10;
    localparam int NUM_PATTERNS = 6;
    localparam int MAX_STEPS    = 6;

    localparam logic [MS_W-1:0] ELAPSED_MAX = '1;

    // LED bit positions inside a level vector
    localparam int LED_RED    = 0;
    localparam int LED_YELLOW = 1;
    localparam int LED_GREEN  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_SET   = 2'd3
    } t_op;

    typedef logic [LED_W-1:0]  t_leds;
    typedef logic [MS_W-1:0]   t_ms;
    typedef logic [STEP_W-1:0] t_step;
    typedef logic [PAT_W-1:0]  t_pat;

    localparam t_step STEP_COUNT [NUM_PATTERNS] = '{
        3'd4, 3'd6, 3'd5, 3'd6, 3'd6, 3'd6
    };

    localparam t_leds STEP_LEVELS [NUM_PATTERNS][MAX_STEPS] = '{
        '{3'b001, 3'b000, 3'b011, 3'b000, 3'b000, 3'b000},
        '{3'b001, 3'b010, 3'b100, 3'b011, 3'b110, 3'b111},
        '{3'b001, 3'b011, 3'b010, 3'b010, 3'b000, 3'b000},
        '{3'b001, 3'b011, 3'b010, 3'b110, 3'b100, 3'b000},
        '{3'b111, 3'b000, 3'b101, 3'b000, 3'b010, 3'b000},
        '{3'b011, 3'b000, 3'b011, 3'b000, 3'b111, 3'b000}
    };

    localparam t_ms STEP_MS [NUM_PATTERNS][MAX_STEPS] = '{
        '{10'd150, 10'd100, 10'd150, 10'd100, 10'd0,   10'd0  },
        '{10'd300, 10'd300, 10'd300, 10'd200, 10'd200, 10'd300},
        '{10'd800, 10'd600, 10'd800, 10'd400, 10'd400, 10'd0  },
        '{10'd500, 10'd400, 10'd500, 10'd400, 10'd500, 10'd300},
        '{10'd80,  10'd50,  10'd100, 10'd50,  10'd100, 10'd50 },
        '{10'd200, 10'd300, 10'd200, 10'd300, 10'd150, 10'd500}
    };

    // Pattern numbers run from 1; table rows from 0
    function automatic logic pattern_ok(input t_pat id);
        return (id >= 3'd1) && (id <= 3'(NUM_PATTERNS));
    endfunction

    function automatic t_step step_count(input t_pat row);
        t_step cnt;
        cnt = '0;
        if (row < 3'(NUM_PATTERNS)) begin
            cnt = STEP_COUNT[row];
        end
        return cnt;
    endfunction

    function automatic t_leds step_levels(input t_pat row, input t_step idx);
        t_leds lv;
        lv = '0;
        if ((row < 3'(NUM_PATTERNS)) && (idx < 3'(MAX_STEPS))) begin
            lv = STEP_LEVELS[row][idx];
        end
        return lv;
    endfunction

    function automatic t_ms step_ms(input t_pat row, input t_step idx);
        t_ms ms;
        ms = '0;
        if ((row < 3'(NUM_PATTERNS)) && (idx < 3'(MAX_STEPS))) begin
            ms = STEP_MS[row][idx];
        end
        return ms;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/led_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// led_pattern_sequencer - three-LED looping pattern sequencer
// Steps red, yellow and green LEDs through six fixed patterns on 1 ms ticks;
// also takes start, stop and direct-set commands. One result per item.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | to block  | i_in_valid / o_in_ready | i_op, i_pattern_id, i_*_in
//  out     | from block| o_out_valid/i_out_ready | o_*_out, o_running,
//          |           |                         | o_bad_pattern
//
//  An item is registered on acceptance in the input register; table lookup and
//  counter logic then update the sequencer state and load the result register.
//  One item per cycle is sustained while the output is not stalled.
//  The state update and the result register share one load enable.
//  i_rst_n is synchronous, active low; it clears both stages' valid flags and
//  all sequencer state. A stalled output holds its result; the input stage keeps
//  accepting until it also holds an item.
// ----------------------------------------------------------------------------
`default_nettype none

module led_pattern_sequencer (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // input channel
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [lps_pkg::OP_W-1:0] i_op,
    input  wire logic [lps_pkg::PAT_W-1:0] i_pattern_id,
    input  wire logic                     i_red_in,
    input  wire logic                     i_yellow_in,
    input  wire logic                     i_green_in,
    // output channel
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic                          o_red_out,
    output logic                          o_yellow_out,
    output logic                          o_green_out,
    output logic                          o_running,
    output logic                          o_bad_pattern
);

    // input register
    logic                 r_in_valid;
    lps_pkg::t_op         r_op;
    lps_pkg::t_pat        r_pattern_id;
    lps_pkg::t_leds       r_set_leds;

    // sequencer state
    lps_pkg::t_leds       r_leds,    n_leds;
    logic                 r_seq,     n_seq;
    lps_pkg::t_pat        r_pat,     n_pat;
    lps_pkg::t_step       r_step,    n_step;
    lps_pkg::t_ms         r_elapsed, n_elapsed;

    // result register
    logic                 r_out_valid;
    lps_pkg::t_leds       r_res_leds;
    logic                 r_res_running;
    logic                 r_res_bad, n_bad;

    logic                 out_free;
    logic                 work_en;

    // tick datapath
    lps_pkg::t_pat        pat_row;
    lps_pkg::t_step       pat_cnt;
    lps_pkg::t_step       cur_step;
    lps_pkg::t_step       inc_step;
    lps_pkg::t_step       nxt_step;
    lps_pkg::t_ms         elapsed_inc;
    logic                 step_done;
    lps_pkg::t_pat        start_row;

    // Output register frees when empty or taken this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    assign work_en    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    // Input stage: take a new item whenever the stage empties or moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op         <= lps_pkg::t_op'(i_op);
            r_pattern_id <= i_pattern_id;
            r_set_leds   <= {i_green_in, i_yellow_in, i_red_in};
        end
    end

    // Current step lookup; an out-of-range index is treated as step 0
    assign pat_row     = r_pat - 3'd1;
    assign pat_cnt     = lps_pkg::step_count(pat_row);
    assign cur_step    = (r_step >= pat_cnt) ? '0 : r_step;
    assign inc_step    = cur_step + 3'd1;
    assign nxt_step    = (inc_step >= pat_cnt) ? '0 : inc_step;
    // Saturate the elapsed count at its top value
    assign elapsed_inc = (r_elapsed < lps_pkg::ELAPSED_MAX) ? r_elapsed + 10'd1 : r_elapsed;
    assign step_done   = elapsed_inc >= lps_pkg::step_ms(pat_row, cur_step);
    assign start_row   = r_pattern_id - 3'd1;

    always_comb begin
        n_leds    = r_leds;
        n_seq     = r_seq;
        n_pat     = r_pat;
        n_step    = r_step;
        n_elapsed = r_elapsed;
        n_bad     = 1'b0;
        case (r_op)
            lps_pkg::OP_TICK: begin
                if (r_seq) begin
                    if (!lps_pkg::pattern_ok(r_pat)) begin
                        // drop a corrupt pattern number
                        n_seq = 1'b0;
                    end else if (step_done) begin
                        n_step    = nxt_step;
                        n_leds    = lps_pkg::step_levels(pat_row, nxt_step);
                        n_elapsed = '0;
                    end else begin
                        n_step    = cur_step;
                        n_elapsed = elapsed_inc;
                    end
                end
            end
            lps_pkg::OP_START: begin
                if (lps_pkg::pattern_ok(r_pattern_id)) begin
                    n_pat     = r_pattern_id;
                    n_step    = '0;
                    n_elapsed = '0;
                    n_seq     = 1'b1;
                    n_leds    = lps_pkg::step_levels(start_row, '0);
                end else begin
                    n_seq = 1'b0;
                    n_bad = 1'b1;
                end
            end
            lps_pkg::OP_STOP: begin
                n_seq = 1'b0;
            end
            lps_pkg::OP_SET: begin
                n_leds = r_set_leds;
            end
            default: begin
                n_leds = r_leds;
            end
        endcase
    end

    // State and result advance together, once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leds    <= '0;
            r_seq     <= 1'b0;
            r_pat     <= '0;
            r_step    <= '0;
            r_elapsed <= '0;
        end else if (work_en) begin
            r_leds    <= n_leds;
            r_seq     <= n_seq;
            r_pat     <= n_pat;
            r_step    <= n_step;
            r_elapsed <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (work_en) begin
            r_res_leds    <= n_leds;
            r_res_running <= n_seq;
            r_res_bad     <= n_bad;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_red_out     = r_res_leds[lps_pkg::LED_RED];
    assign o_yellow_out  = r_res_leds[lps_pkg::LED_YELLOW];
    assign o_green_out   = r_res_leds[lps_pkg::LED_GREEN];
    assign o_running     = r_res_running;
    assign o_bad_pattern = r_res_bad;

endmodule

`default_nettype wire

// ===== rtl/core/lps_checker.sv =====
// ----------------------------------------------------------------------------
// lps_checker - port-level checks of the LED pattern sequencer
// Watches the top level's handshakes and result fields; bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_pattern_sequencer_defines.svh"

module lps_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      o_in_ready,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_ready,
    input wire logic                      o_red_out,
    input wire logic                      o_yellow_out,
    input wire logic                      o_green_out,
    input wire logic                      o_running,
    input wire logic                      o_bad_pattern
);

    logic [4:0] res_bits;

    assign res_bits = {o_red_out, o_yellow_out, o_green_out, o_running, o_bad_pattern};

    // a rejected start never leaves a pattern running
    `LPS_ASSERT_SAME(a_bad_not_running, i_clk, i_rst_n, o_out_valid && o_bad_pattern, !o_running)

    // input backs up only behind a held result
    `LPS_ASSERT_SAME(a_ready_low, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready)

    // hold a stalled result
    `LPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    `LPS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(res_bits))

endmodule

bind led_pattern_sequencer lps_checker u_lps_checker (.*);

`default_nettype wire

// ===== dv/led_pattern_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pattern_sequencer_tb - self-checking bench for the LED pattern sequencer
// Runs directed commands, then random start/tick/stop/set sequences, through
// the valid/ready input channel with bursty traffic. A local model of the
// pattern table and step timer predicts every result. A monitor compares
// the predictions in order with what the block returns under random
// back-pressure.
// ----------------------------------------------------------------------------

module led_pattern_sequencer_tb;

    localparam int CLK_PERIOD  = 20;
    localparam int RESET_LEN   = 11;
    localparam int RANDOM_LEN  = 600;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;
    localparam int MAX_REPORTS = 10;

    // receiver back-pressure modes
    localparam int RX_FULL = 0;
    localparam int RX_HALF = 1;
    localparam int RX_SLOW = 2;

    // pattern table: red is bit 0, yellow bit 1, green bit 2
    localparam int PAT_STEPS [lps_pkg::NUM_PATTERNS] = '{4, 6, 5, 6, 6, 6};

    localparam lps_pkg::t_leds PAT_LEVELS [lps_pkg::NUM_PATTERNS][lps_pkg::MAX_STEPS] = '{
        '{3'b001, 3'b000, 3'b011, 3'b000, 3'b000, 3'b000},
        '{3'b001, 3'b010, 3'b100, 3'b011, 3'b110, 3'b111},
        '{3'b001, 3'b011, 3'b010, 3'b010, 3'b000, 3'b000},
        '{3'b001, 3'b011, 3'b010, 3'b110, 3'b100, 3'b000},
        '{3'b111, 3'b000, 3'b101, 3'b000, 3'b010, 3'b000},
        '{3'b011, 3'b000, 3'b011, 3'b000, 3'b111, 3'b000}
    };

    localparam int PAT_DUR [lps_pkg::NUM_PATTERNS][lps_pkg::MAX_STEPS] = '{
        '{150, 100, 150, 100,   0,   0},
        '{300, 300, 300, 200, 200, 300},
        '{800, 600, 800, 400, 400,   0},
        '{500, 400, 500, 400, 500, 300},
        '{ 80,  50, 100,  50, 100,  50},
        '{200, 300, 200, 300, 150, 500}
    };

    typedef struct packed {
        lps_pkg::t_op   op;
        lps_pkg::t_pat  pid;
        lps_pkg::t_leds rgb;     // bit 0 red, bit 1 yellow, bit 2 green
    } t_led_cmd;

    typedef struct packed {
        logic red;
        logic yellow;
        logic green;
        logic running;
        logic bad;
    } t_led_status;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic i_clk;
    logic rst_n;

    logic           drv_valid;
    lps_pkg::t_op   drv_op;
    lps_pkg::t_pat  drv_pid;
    lps_pkg::t_leds drv_rgb;
    logic           out_rdy;

    logic o_in_ready;
    logic o_out_valid;
    logic o_red_out;
    logic o_yellow_out;
    logic o_green_out;
    logic o_running;
    logic o_bad_pattern;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    led_pattern_sequencer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (drv_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (drv_op),
        .i_pattern_id  (drv_pid),
        .i_red_in      (drv_rgb[0]),
        .i_yellow_in   (drv_rgb[1]),
        .i_green_in    (drv_rgb[2]),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_rdy),
        .o_red_out     (o_red_out),
        .o_yellow_out  (o_yellow_out),
        .o_green_out   (o_green_out),
        .o_running     (o_running),
        .o_bad_pattern (o_bad_pattern)
    );

    // ------------------------------------------------------------------------
    // Sequencer prediction: own copy of the LED levels, run flag, pattern,
    // step and millisecond count.
    // ------------------------------------------------------------------------
    lps_pkg::t_leds seq_leds;
    logic           seq_on;
    lps_pkg::t_pat  seq_pat;
    lps_pkg::t_step seq_step_idx;
    lps_pkg::t_ms   seq_elapsed;

    int    step_changes;
    int    wraps_seen;
    int    bad_starts;
    int    op_seen [4];

    function automatic t_led_status advance_sequencer(input t_led_cmd c);
        t_led_status res;
        int          row;
        int          nxt;
        res.bad = 1'b0;
        case (c.op)
            lps_pkg::OP_TICK: begin
                if (seq_on) begin
                    if (seq_pat < 1 || seq_pat > lps_pkg::NUM_PATTERNS) begin
                        // drop a pattern that cannot be sequenced
                        seq_on = 1'b0;
                    end else begin
                        row = int'(seq_pat) - 1;
                        if (int'(seq_step_idx) >= PAT_STEPS[row]) begin
                            seq_step_idx = '0;
                        end
                        if (seq_elapsed != '1) begin
                            seq_elapsed = seq_elapsed + 1'b1;
                        end
                        if (int'(seq_elapsed) >= PAT_DUR[row][seq_step_idx]) begin
                            nxt = int'(seq_step_idx) + 1;
                            if (nxt >= PAT_STEPS[row]) begin
                                nxt = 0;
                                wraps_seen++;
                            end
                            seq_step_idx = lps_pkg::t_step'(nxt);
                            seq_leds     = PAT_LEVELS[row][nxt];
                            seq_elapsed  = '0;
                            step_changes++;
                        end
                    end
                end
            end
            lps_pkg::OP_START: begin
                if (c.pid >= 1 && c.pid <= lps_pkg::NUM_PATTERNS) begin
                    seq_pat      = c.pid;
                    seq_step_idx = '0;
                    seq_elapsed  = '0;
                    seq_on       = 1'b1;
                    seq_leds     = PAT_LEVELS[int'(c.pid) - 1][0];
                end else begin
                    seq_on  = 1'b0;
                    res.bad = 1'b1;
                    bad_starts++;
                end
            end
            lps_pkg::OP_STOP: begin
                seq_on = 1'b0;
            end
            default: begin
                seq_leds = c.rgb;
            end
        endcase
        op_seen[c.op]++;
        res.red     = seq_leds[lps_pkg::LED_RED];
        res.yellow  = seq_leds[lps_pkg::LED_YELLOW];
        res.green   = seq_leds[lps_pkg::LED_GREEN];
        res.running = seq_on;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Queues between stimulus, driver, prediction and monitor
    // ------------------------------------------------------------------------
    t_led_cmd    cmd_q [$];
    t_led_status led_expect_q [$];

    int   cycles;
    int   results_checked;
    int   err_cnt;
    logic in_taken;

    task automatic queue_cmd(input lps_pkg::t_op op, input lps_pkg::t_pat pid,
                             input lps_pkg::t_leds rgb);
        t_led_cmd c;
        c.op  = op;
        c.pid = pid;
        c.rgb = rgb;
        cmd_q.push_back(c);
    endtask

    // Random pattern number and LED bits ride along on every item so each
    // input bit toggles even where the block ignores it.
    task automatic queue_noisy(input lps_pkg::t_op op);
        queue_cmd(op, lps_pkg::t_pat'($urandom), lps_pkg::t_leds'($urandom));
    endtask

    task automatic queue_ticks(input int n);
        for (int k = 0; k < n; k++) begin
            queue_noisy(lps_pkg::OP_TICK);
        end
    endtask

    // Hold until every queued item is accepted and every result is back.
    task automatic wait_drained();
        while (cmd_q.size() != 0 || drv_valid || led_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic report_mismatch(input string what, input t_led_status exp_s,
                                   input t_led_status got_s);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
            $display("[%0t] %s: expected r%b y%b g%b run%b bad%b, got r%b y%b g%b run%b bad%b",
                     $realtime, what, exp_s.red, exp_s.yellow, exp_s.green,
                     exp_s.running, exp_s.bad, got_s.red, got_s.yellow,
                     got_s.green, got_s.running, got_s.bad);
        end
    endtask

    // ------------------------------------------------------------------------
    // Rising edge: predict on input acceptance, check on output acceptance,
    // watch the cycle limit.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_led_cmd    acc;
        t_led_status got;
        t_led_status exp_s;
        cycles   <= cycles + 1;
        in_taken <= drv_valid && o_in_ready;
        if (rst_n) begin
            if (o_out_valid && out_rdy) begin
                got.red     = o_red_out;
                got.yellow  = o_yellow_out;
                got.green   = o_green_out;
                got.running = o_running;
                got.bad     = o_bad_pattern;
                if (led_expect_q.size() == 0) begin
                    report_mismatch("unexpected result", '0, got);
                end else begin
                    exp_s = led_expect_q.pop_front();
                    results_checked++;
                    if (got.red !== exp_s.red || got.yellow !== exp_s.yellow ||
                        got.green !== exp_s.green || got.running !== exp_s.running ||
                        got.bad !== exp_s.bad) begin
                        report_mismatch("result mismatch", exp_s, got);
                    end
                end
            end
            if (drv_valid && o_in_ready) begin
                acc.op  = drv_op;
                acc.pid = drv_pid;
                acc.rgb = drv_rgb;
                led_expect_q.push_back(advance_sequencer(acc));
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: bursts of items with random gaps; payload held until accepted
    // ------------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(negedge i_clk) begin
        t_led_cmd c;
        if (rst_n && (!drv_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left  <= gap_left - 1;
                drv_valid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                c = cmd_q.pop_front();
                drv_valid <= 1'b1;
                drv_op    <= c.op;
                drv_pid   <= c.pid;
                drv_rgb   <= c.rgb;
                if (burst_left <= 1) begin
                    // end of burst: pick the next one and the gap before it
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: phases of full rate, coin-flip stalls and heavy stalls
    // ------------------------------------------------------------------------
    int rx_mode;
    int rx_left;

    always @(negedge i_clk) begin
        if (rst_n) begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(RX_FULL, RX_SLOW);
                rx_left <= $urandom_range(16, 96);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RX_FULL: out_rdy <= 1'b1;
                RX_HALF: out_rdy <= $urandom_range(0, 1);
                default: out_rdy <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int            queued;
        int            run;
        int            pick;
        lps_pkg::t_pat pid;

        rst_n       = 1'b0;
        drv_valid   = 1'b0;
        drv_op      = lps_pkg::OP_TICK;
        drv_pid     = '0;
        drv_rgb     = '0;
        out_rdy     = 1'b0;
        in_taken    = 1'b0;
        cycles      = 0;
        burst_left  = 0;
        gap_left    = 0;
        rx_mode     = RX_FULL;
        rx_left     = 0;
        err_cnt     = 0;
        results_checked = 0;
        step_changes = 0;
        wraps_seen   = 0;
        bad_starts   = 0;
        op_seen      = '{0, 0, 0, 0};
        seq_leds     = '0;
        seq_on       = 1'b0;
        seq_pat      = '0;
        seq_step_idx = '0;
        seq_elapsed  = '0;

        repeat (RESET_LEN) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // Directed: idle tick and stop, direct sets at the extremes, both
        // invalid pattern numbers, every valid pattern, a set and restart
        // while running, an invalid start that halts a running pattern.
        queue_cmd(lps_pkg::OP_TICK,  3'd0, 3'b111);
        queue_cmd(lps_pkg::OP_STOP,  3'd7, 3'b111);
        queue_cmd(lps_pkg::OP_SET,   3'd0, 3'b111);
        queue_cmd(lps_pkg::OP_SET,   3'd7, 3'b000);
        queue_cmd(lps_pkg::OP_SET,   3'd0, 3'b101);
        queue_cmd(lps_pkg::OP_SET,   3'd0, 3'b010);
        queue_cmd(lps_pkg::OP_START, 3'd0, 3'b000);
        queue_cmd(lps_pkg::OP_TICK,  3'd0, 3'b000);
        queue_cmd(lps_pkg::OP_START, 3'd7, 3'b111);
        for (int p = 1; p <= lps_pkg::NUM_PATTERNS; p++) begin
            queue_cmd(lps_pkg::OP_START, lps_pkg::t_pat'(p), 3'b000);
            queue_cmd(lps_pkg::OP_TICK,  lps_pkg::t_pat'(p), 3'b000);
        end
        queue_cmd(lps_pkg::OP_SET,   3'd5, 3'b110);
        queue_cmd(lps_pkg::OP_TICK,  3'd5, 3'b000);
        queue_cmd(lps_pkg::OP_START, 3'd5, 3'b000);
        queue_cmd(lps_pkg::OP_STOP,  3'd0, 3'b000);
        queue_cmd(lps_pkg::OP_TICK,  3'd0, 3'b000);
        queue_cmd(lps_pkg::OP_START, 3'd5, 3'b000);
        queue_cmd(lps_pkg::OP_START, 3'd7, 3'b000);
        queue_cmd(lps_pkg::OP_STOP,  3'd0, 3'b000);

        // hold off the sender until the block has drained completely
        wait_drained();

        // Random: mostly start-then-tick runs so steps advance and wrap,
        // with stops, bad starts, sets and fully random noise mixed in.
        queued = 0;
        while (queued < RANDOM_LEN) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                // favor the short patterns so step changes come often
                case ($urandom_range(0, 5))
                    0, 1, 2: pid = 3'd5;
                    3:       pid = 3'd1;
                    default: pid = lps_pkg::t_pat'($urandom_range(1, lps_pkg::NUM_PATTERNS));
                endcase
                queue_cmd(lps_pkg::OP_START, pid, lps_pkg::t_leds'($urandom));
                run = ($urandom_range(0, 5) == 0) ? $urandom_range(400, 520)
                                                  : $urandom_range(1, 160);
                for (int k = 0; k < run; k++) begin
                    if ($urandom_range(0, 39) == 0) begin
                        queue_cmd(lps_pkg::OP_SET, lps_pkg::t_pat'($urandom),
                                  lps_pkg::t_leds'($urandom));
                    end else begin
                        queue_noisy(lps_pkg::OP_TICK);
                    end
                end
                queued += run + 1;
            end else if (pick == 6) begin
                queue_noisy(lps_pkg::OP_STOP);
                run = $urandom_range(1, 6);
                queue_ticks(run);
                queued += run + 1;
            end else if (pick == 7) begin
                queue_cmd(lps_pkg::OP_START, ($urandom_range(0, 1) != 0) ? 3'd7 : 3'd0,
                          lps_pkg::t_leds'($urandom));
                run = $urandom_range(1, 6);
                queue_ticks(run);
                queued += run + 1;
            end else if (pick == 8) begin
                run = $urandom_range(5, 15);
                for (int k = 0; k < run; k++) begin
                    queue_cmd(lps_pkg::t_op'($urandom), lps_pkg::t_pat'($urandom),
                              lps_pkg::t_leds'($urandom));
                end
                queued += run;
            end else begin
                queue_cmd(lps_pkg::OP_SET, lps_pkg::t_pat'($urandom),
                          lps_pkg::t_leds'($urandom));
                queued += 1;
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Checked %0d results: %0d ticks, %0d starts, %0d stops, %0d sets",
                 results_checked, op_seen[lps_pkg::OP_TICK], op_seen[lps_pkg::OP_START],
                 op_seen[lps_pkg::OP_STOP], op_seen[lps_pkg::OP_SET]);
        $display("Saw %0d step changes, %0d pattern wraps, %0d invalid starts, %0d errors",
                 step_changes, wraps_seen, bad_starts, err_cnt);
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
